@@ src/i2cm_pkg.sv @@
package i2cm_pkg;

   localparam int unsigned BYTE_W        = 8;
   localparam int unsigned COUNT_W       = 8;
   localparam int unsigned BIT_COUNT_W   = 4;
   localparam int unsigned CSR_INDEX_W   = 2;
   localparam int unsigned REQ_TDATA_W   = 16;
   localparam int unsigned REQ_TUSER_W   = 4;
   localparam int unsigned RSP_TDATA_W   = 16;

   localparam logic [BIT_COUNT_W-1:0] BITS_PER_BYTE = 4'd8;

   localparam logic [COUNT_W-1:0] HOLD_TICKS_RESET  = 8'd4;
   localparam logic [COUNT_W-1:0] PHASE_TICKS_RESET = 8'd2;
   localparam logic [COUNT_W-1:0] ACK_TIMEOUT_RESET = 8'd25;

   localparam logic [CSR_INDEX_W-1:0] CSR_HOLD_TICKS  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_TICKS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACK_TIMEOUT = 2'd2;

   localparam logic [2:0] OP_START    = 3'd0;
   localparam logic [2:0] OP_STOP     = 3'd1;
   localparam logic [2:0] OP_WRITE    = 3'd2;
   localparam logic [2:0] OP_WAIT_ACK = 3'd3;
   localparam logic [2:0] OP_READ     = 3'd4;
   localparam logic [2:0] OP_ACK_BIT  = 3'd5;

   localparam logic [1:0] STEP_ZERO = 2'd0;
   localparam logic [1:0] STEP_ONE  = 2'd1;
   localparam logic [1:0] STEP_TWO  = 2'd2;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_START,
      CMD_STOP,
      CMD_WRITE,
      CMD_WAIT_ACK,
      CMD_READ,
      CMD_ACK_BIT
   } cmd_type;

   typedef enum logic [6:0] {
      MODE_IDLE     = 7'b0000001,
      MODE_START    = 7'b0000010,
      MODE_STOP     = 7'b0000100,
      MODE_WRITE    = 7'b0001000,
      MODE_WAIT_ACK = 7'b0010000,
      MODE_READ     = 7'b0100000,
      MODE_ACK_BIT  = 7'b1000000
   } mode_type;

   typedef struct packed {
      cmd_type            kind;
      logic [BYTE_W-1:0]  tx_byte;
      logic               ack_flag;
      logic               sda_level;
   } item_type;

endpackage

@@ src/i2cm_front.sv @@
module i2cm_front
   import i2cm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // tdata: tx_byte[7:0], ack_flag[8], sda_level[9], zero fill[15:10]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // tuser: cmd_valid[0], opcode[3:1]
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   item_valid,
   input  logic                   item_ready,
   output item_type               item
);

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   decoded;
   logic       push, pop;

   always_comb begin
      decoded.tx_byte   = req_tdata[BYTE_W-1:0];
      decoded.ack_flag  = req_tdata[8];
      decoded.sda_level = req_tdata[9];
      decoded.kind      = CMD_NONE;
      if (req_tuser[0]) begin
         unique case (req_tuser[3:1])
            OP_START:    decoded.kind = CMD_START;
            OP_STOP:     decoded.kind = CMD_STOP;
            OP_WRITE:    decoded.kind = CMD_WRITE;
            OP_WAIT_ACK: decoded.kind = CMD_WAIT_ACK;
            OP_READ:     decoded.kind = CMD_READ;
            OP_ACK_BIT:  decoded.kind = CMD_ACK_BIT;
            default:     decoded.kind = CMD_NONE;
         endcase
      end
   end

   assign req_tready = (count_ff != 2'd2);
   assign item_valid = (count_ff != 2'd0);
   assign item       = entry_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = item_valid && item_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

@@ src/i2cm_engine.sv @@
module i2cm_engine
   import i2cm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COUNT_W-1:0]     csr_data,
   input  logic                   item_valid,
   output logic                   item_ready,
   input  item_type               item,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // tdata: scl_level[0], sda_release[1], busy_res[2], done_res[3],
   // rx_byte[11:4], ack_fail[12], zero fill[15:13]
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [COUNT_W-1:0]     hold_ticks_ff, phase_ticks_ff, ack_timeout_ff;
   mode_type               mode_ff, mode_in;
   logic [1:0]             step_ff, step_in;
   logic [COUNT_W-1:0]     tick_ff, tick_in;
   logic [BIT_COUNT_W-1:0] bit_count_ff, bit_count_in;
   logic [BYTE_W-1:0]      shift_ff, shift_in;
   logic [COUNT_W-1:0]     poll_ff, poll_in;
   logic                   pending_ack_ff, pending_ack_in;
   logic                   scl_ff, scl_in;
   logic                   sda_ff, sda_in;
   logic                   fail_ff, fail_in;
   logic [BYTE_W-1:0]      rx_hold_ff, rx_hold_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0]     phase_raw, phase_len;
   logic [BIT_COUNT_W-1:0] bit_next;
   logic                   done;
   logic                   advance;

   assign csr_ready  = 1'b1;
   assign item_ready = !rsp_valid_ff || rsp_tready;
   assign advance    = item_valid && item_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign phase_raw = (mode_ff == MODE_START || mode_ff == MODE_STOP) ?
                      hold_ticks_ff : phase_ticks_ff;
   assign phase_len = (phase_raw == '0) ? COUNT_W'(1) : phase_raw;
   assign bit_next  = bit_count_ff + BIT_COUNT_W'(1);

   always_comb begin
      mode_in        = mode_ff;
      step_in        = step_ff;
      tick_in        = tick_ff;
      bit_count_in   = bit_count_ff;
      shift_in       = shift_ff;
      poll_in        = poll_ff;
      pending_ack_in = pending_ack_ff;
      scl_in         = scl_ff;
      sda_in         = sda_ff;
      fail_in        = fail_ff;
      rx_hold_in     = rx_hold_ff;
      done           = 1'b0;

      if (mode_ff == MODE_IDLE) begin
         unique case (item.kind)
            CMD_NONE: begin
            end
            CMD_START: begin
               sda_in  = 1'b1;
               scl_in  = 1'b1;
               mode_in = MODE_START;
               step_in = STEP_ZERO;
               tick_in = COUNT_W'(1);
            end
            CMD_STOP: begin
               scl_in  = 1'b0;
               sda_in  = 1'b0;
               mode_in = MODE_STOP;
               step_in = STEP_ZERO;
               tick_in = COUNT_W'(1);
            end
            CMD_WRITE: begin
               shift_in     = item.tx_byte;
               bit_count_in = '0;
               scl_in       = 1'b0;
               sda_in       = item.tx_byte[BYTE_W-1];
               mode_in      = MODE_WRITE;
               step_in      = STEP_ZERO;
               tick_in      = COUNT_W'(1);
            end
            CMD_WAIT_ACK: begin
               fail_in = 1'b0;
               poll_in = '0;
               sda_in  = 1'b1;
               mode_in = MODE_WAIT_ACK;
               step_in = STEP_ZERO;
               tick_in = COUNT_W'(1);
            end
            CMD_READ: begin
               shift_in       = '0;
               bit_count_in   = '0;
               pending_ack_in = item.ack_flag;
               scl_in         = 1'b0;
               sda_in         = 1'b1;
               mode_in        = MODE_READ;
               step_in        = STEP_ZERO;
               tick_in        = COUNT_W'(1);
            end
            CMD_ACK_BIT: begin
               pending_ack_in = item.ack_flag;
               scl_in         = 1'b0;
               sda_in         = !item.ack_flag;
               mode_in        = MODE_ACK_BIT;
               step_in        = STEP_ZERO;
               tick_in        = COUNT_W'(1);
            end
            default: begin
            end
         endcase
      end else if (mode_ff == MODE_WAIT_ACK && step_ff == STEP_TWO) begin
         if (!item.sda_level) begin
            scl_in = 1'b0;
            done   = 1'b1;
         end else if (poll_ff >= ack_timeout_ff) begin
            fail_in = 1'b1;
            scl_in  = 1'b0;
            sda_in  = 1'b0;
            mode_in = MODE_STOP;
            step_in = STEP_ZERO;
            tick_in = COUNT_W'(1);
         end else begin
            poll_in = poll_ff + COUNT_W'(1);
         end
      end else if (tick_ff < phase_len) begin
         tick_in = tick_ff + COUNT_W'(1);
      end else begin
         tick_in = COUNT_W'(1);
         unique case (mode_ff)
            MODE_IDLE: begin
               done = 1'b1;
            end
            MODE_START: begin
               if (step_ff == STEP_ZERO) begin
                  sda_in  = 1'b0;
                  step_in = STEP_ONE;
               end else begin
                  scl_in = 1'b0;
                  done   = 1'b1;
               end
            end
            MODE_STOP: begin
               if (step_ff == STEP_ZERO) begin
                  scl_in  = 1'b1;
                  sda_in  = 1'b1;
                  step_in = STEP_ONE;
               end else begin
                  done = 1'b1;
               end
            end
            MODE_WRITE: begin
               if (step_ff == STEP_ZERO) begin
                  scl_in  = 1'b1;
                  step_in = STEP_ONE;
               end else if (step_ff == STEP_ONE) begin
                  scl_in  = 1'b0;
                  step_in = STEP_TWO;
               end else begin
                  bit_count_in = bit_next;
                  if (bit_next >= BITS_PER_BYTE) begin
                     done = 1'b1;
                  end else begin
                     sda_in  = shift_ff[~bit_next[2:0]];
                     step_in = STEP_ZERO;
                  end
               end
            end
            MODE_WAIT_ACK: begin
               if (step_ff == STEP_ZERO) begin
                  scl_in  = 1'b1;
                  step_in = STEP_ONE;
               end else begin
                  poll_in = '0;
                  step_in = STEP_TWO;
               end
            end
            MODE_READ: begin
               if (step_ff == STEP_ZERO) begin
                  scl_in   = 1'b1;
                  shift_in = {shift_ff[BYTE_W-2:0], item.sda_level};
                  step_in  = STEP_ONE;
               end else begin
                  bit_count_in = bit_next;
                  scl_in       = 1'b0;
                  step_in      = STEP_ZERO;
                  if (bit_next >= BITS_PER_BYTE) begin
                     rx_hold_in = shift_ff;
                     sda_in     = !pending_ack_ff;
                     mode_in    = MODE_ACK_BIT;
                  end
               end
            end
            MODE_ACK_BIT: begin
               if (step_ff == STEP_ZERO) begin
                  scl_in  = 1'b1;
                  step_in = STEP_ONE;
               end else begin
                  scl_in = 1'b0;
                  done   = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (done) begin
         mode_in = MODE_IDLE;
         step_in = STEP_ZERO;
         tick_in = '0;
      end

      rsp_data_in = {3'b000, fail_in, rx_hold_in, done,
                     (mode_in != MODE_IDLE), sda_in, scl_in};
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff  <= HOLD_TICKS_RESET;
         phase_ticks_ff <= PHASE_TICKS_RESET;
         ack_timeout_ff <= ACK_TIMEOUT_RESET;
         mode_ff        <= MODE_IDLE;
         step_ff        <= STEP_ZERO;
         tick_ff        <= '0;
         bit_count_ff   <= '0;
         shift_ff       <= '0;
         poll_ff        <= '0;
         pending_ack_ff <= 1'b0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         fail_ff        <= 1'b0;
         rx_hold_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            mode_ff        <= mode_in;
            step_ff        <= step_in;
            tick_ff        <= tick_in;
            bit_count_ff   <= bit_count_in;
            shift_ff       <= shift_in;
            poll_ff        <= poll_in;
            pending_ack_ff <= pending_ack_in;
            scl_ff         <= scl_in;
            sda_ff         <= sda_in;
            fail_ff        <= fail_in;
            rx_hold_ff     <= rx_hold_in;
         end
         if (csr_valid) begin
            unique case (csr_index)
               CSR_HOLD_TICKS:  hold_ticks_ff  <= csr_data;
               CSR_PHASE_TICKS: phase_ticks_ff <= csr_data;
               CSR_ACK_TIMEOUT: ack_timeout_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

@@ src/i2c_master_bit_engine_top.sv @@
// A word accepted on req is held in a two-entry queue and then in a registered
// result stage before it appears on rsp. Throughput: one word per clock cycle while
// rsp_tready holds, set by the tick update of the engine on every accepted word.
// Reset is synchronous and active high: the bus is released (SCL and SDA high),
// the engine is idle and the tick registers return to 4, 2 and 25.
module i2c_master_bit_engine_top
   import i2cm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // tdata: tx_byte[7:0], ack_flag[8], sda_level[9], zero fill[15:10]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // tuser: cmd_valid[0], opcode[3:1]
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // tdata: scl_level[0], sda_release[1], busy_res[2], done_res[3],
   // rx_byte[11:4], ack_fail[12], zero fill[15:13]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COUNT_W-1:0]     csr_data
);

   logic     item_valid;
   logic     item_ready;
   item_type item;

   i2cm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item)
   );

   i2cm_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
